### sv/sfnf_pkg.sv
// Shared types and constants of the single failure node finder.
package sfnf_pkg;

   localparam int MAX_NODES_DEFAULT = 32;
   localparam int MAX_RESULTS       = 32;
   localparam int RESULT_COUNT_W    = $clog2(MAX_RESULTS + 1);

   localparam int NODE_COUNT_W = 6;
   localparam int EDGE_W       = 6;
   localparam int NODE_INDEX_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 6'd1;
   localparam logic [CSR_ADDR_W-3:0]   REG_NODE_COUNT   = 1'b0;

   localparam logic CMD_ADD_EDGE = 1'b0;
   localparam logic CMD_RUN      = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [EDGE_W-1:0] edge_start;
      logic [EDGE_W-1:0] edge_end;
   } req_payload_type;

   typedef struct packed {
      logic                    found;
      logic [NODE_INDEX_W-1:0] node_index;
      logic                    last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      RD_EDGE_START,
      RD_EDGE_END,
      RD_WALK
   } rd_src_type;

   typedef enum logic {
      WR_EDGE_START,
      WR_EDGE_END
   } wr_src_type;

   typedef enum logic [1:0] {
      EMIT_HOLD_MID,
      EMIT_HOLD_LAST,
      EMIT_NONE_FOUND
   } emit_kind_type;

   typedef struct packed {
      logic          load_req;
      logic          rd_en;
      rd_src_type    rd_src;
      logic          wr_en;
      wr_src_type    wr_src;
      logic          run_start;
      logic          walk_init;
      logic          walk_pop;
      logic          walk_expand;
      logic          hold_load;
      logic          cand_next;
      logic          emit_en;
      emit_kind_type emit_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic edge_ok;
      logic f_done;
      logic start_ok;
      logic pending_empty;
      logic connected;
      logic hold_valid;
      logic k_last;
      logic out_free;
   } dp_status_type;

endpackage

### sv/single_failure_node_finder_unit.sv
// Edge add: take the transfer, then read-modify-write the matrix rows of both endpoints.
// Run: take the transfer, then walk from a start node without each candidate node, which is
// critical if the walk misses a node. Output stalls can hold the run; a last result closes it.
// One item is in work at a time; a finished result waits in the output register.
// Reset (synchronous): no edges (row valid bits cleared at once, no clearing pass),
// node_count back to 1, controller idle, no result pending.
module single_failure_node_finder_unit #(
   parameter int MAX_NODES = sfnf_pkg::MAX_NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sfnf_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sfnf_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfnf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfnf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfnf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sfnf_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   sfnf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   sfnf_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (ctrl_cmd),
      .status      (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

endmodule

### sv/sfnf_datapath.sv
// Datapath: adjacency memory, walk sets and counters, result register, CSR.
module sfnf_datapath #(
   parameter int MAX_NODES = sfnf_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sfnf_pkg::req_payload_type             req_payload,
   input  sfnf_pkg::ctrl_cmd_type                cmd,
   output sfnf_pkg::dp_status_type               status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sfnf_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sfnf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sfnf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sfnf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import sfnf_pkg::*;

   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int KW = RESULT_COUNT_W;

   // configuration
   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic                    csr_wr;
   logic                    reg_sel;
   logic [CW-1:0]           n_use;
   logic [MAX_NODES-1:0]    use_mask;

   // edge endpoints
   logic [IW-1:0] edge_s_ff, edge_s_in;
   logic [IW-1:0] edge_e_ff, edge_e_in;

   // adjacency memory
   logic [MAX_NODES-1:0] adj_mem_ff [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff, row_valid_in;
   logic [MAX_NODES-1:0] rd_row_ff;
   logic                 rd_valid_ff;
   logic [MAX_NODES-1:0] row_eff;
   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        wr_addr;
   logic [IW-1:0]        wr_other;
   logic [MAX_NODES-1:0] wr_data;

   // walk
   logic [CW-1:0]        f_ff, f_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic [CW-1:0]        hold_idx_ff, hold_idx_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] pending_ff, pending_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        start_cnt;
   logic [IW-1:0]        start_idx;
   logic [IW-1:0]        fail_idx;
   logic [IW-1:0]        pop_idx;
   logic [MAX_NODES-1:0] new_bits;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_NODE_COUNT);

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_wr && reg_sel) begin
         node_count_in = csr_pwdata[NODE_COUNT_W-1:0];
      end
      csr_prdata = reg_sel ? CSR_DATA_W'(node_count_ff) : '0;
   end

   // saturate the count to the matrix size
   always_comb begin
      if (int'(node_count_ff) > MAX_NODES) begin
         n_use = CW'(MAX_NODES);
      end else begin
         n_use = CW'(node_count_ff);
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         use_mask[i] = (i < int'(n_use));
      end
   end

   // ---------------- edge load ----------------
   always_comb begin
      edge_s_in = edge_s_ff;
      edge_e_in = edge_e_ff;
      if (cmd.load_req) begin
         edge_s_in = IW'(req_payload.edge_start);
         edge_e_in = IW'(req_payload.edge_end);
      end
   end

   // ---------------- adjacency memory ----------------
   always_comb begin
      case (cmd.rd_src)
         RD_EDGE_START: rd_addr = edge_s_ff;
         RD_EDGE_END:   rd_addr = edge_e_ff;
         RD_WALK:       rd_addr = pop_idx;
         default:       rd_addr = pop_idx;
      endcase
      if (cmd.wr_src == WR_EDGE_END) begin
         wr_addr  = edge_e_ff;
         wr_other = edge_s_ff;
      end else begin
         wr_addr  = edge_s_ff;
         wr_other = edge_e_ff;
      end
      // a row never written reads as empty
      row_eff      = rd_valid_ff ? rd_row_ff : '0;
      wr_data      = row_eff | (MAX_NODES'(1) << wr_other);
      row_valid_in = row_valid_ff;
      if (cmd.wr_en) begin
         row_valid_in = row_valid_ff | (MAX_NODES'(1) << wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         adj_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_row_ff   <= adj_mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // ---------------- walk ----------------
   always_comb begin
      start_cnt = (f_ff == '0) ? CW'(1) : '0;
      start_idx = start_cnt[IW-1:0];
      fail_idx  = f_ff[IW-1:0];
      // lowest pending node
      pop_idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pop_idx = IW'(i);
         end
      end
      new_bits = row_eff & use_mask & ~visited_ff & ~(MAX_NODES'(1) << fail_idx);
   end

   always_comb begin
      f_in          = f_ff;
      k_in          = k_ff;
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      visited_in    = visited_ff;
      pending_in    = pending_ff;
      count_in      = count_ff;
      if (cmd.run_start) begin
         f_in          = '0;
         k_in          = '0;
         hold_valid_in = 1'b0;
      end
      if (cmd.cand_next) begin
         f_in = f_ff + CW'(1);
      end
      if (cmd.hold_load) begin
         k_in          = k_ff + KW'(1);
         hold_valid_in = 1'b1;
         hold_idx_in   = f_ff;
      end
      if (cmd.walk_init) begin
         visited_in = MAX_NODES'(1) << start_idx;
         pending_in = MAX_NODES'(1) << start_idx;
         count_in   = '0;
      end
      if (cmd.walk_pop) begin
         pending_in = pending_ff & ~(MAX_NODES'(1) << pop_idx);
         count_in   = count_ff + CW'(1);
      end
      if (cmd.walk_expand) begin
         visited_in = visited_ff | new_bits;
         pending_in = pending_ff | new_bits;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_en) begin
         rsp_valid_in = 1'b1;
         case (cmd.emit_kind)
            EMIT_HOLD_MID: begin
               rsp_payload_in.found      = 1'b1;
               rsp_payload_in.node_index = NODE_INDEX_W'(hold_idx_ff);
               rsp_payload_in.last       = 1'b0;
            end
            EMIT_HOLD_LAST: begin
               rsp_payload_in.found      = 1'b1;
               rsp_payload_in.node_index = NODE_INDEX_W'(hold_idx_ff);
               rsp_payload_in.last       = 1'b1;
            end
            default: begin
               rsp_payload_in.found      = 1'b0;
               rsp_payload_in.node_index = '0;
               rsp_payload_in.last       = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- status ----------------
   always_comb begin
      status.edge_ok = (int'(req_payload.edge_start) < int'(n_use)) &&
                       (int'(req_payload.edge_end) < int'(n_use));
      status.f_done        = (f_ff == n_use);
      status.start_ok      = (start_cnt < n_use);
      status.pending_empty = (pending_ff == '0);
      status.connected     = (count_ff == (n_use - CW'(1)));
      status.hold_valid    = hold_valid_ff;
      status.k_last        = (k_ff == KW'(MAX_RESULTS - 1));
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         row_valid_ff  <= '0;
         f_ff          <= '0;
         k_ff          <= '0;
         hold_valid_ff <= 1'b0;
         visited_ff    <= '0;
         pending_ff    <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         row_valid_ff  <= row_valid_in;
         f_ff          <= f_in;
         k_ff          <= k_in;
         hold_valid_ff <= hold_valid_in;
         visited_ff    <= visited_in;
         pending_ff    <= pending_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_s_ff      <= edge_s_in;
      edge_e_ff      <= edge_e_in;
      hold_idx_ff    <= hold_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

### sv/sfnf_controller.sv
// Controller: sequences edge loads and the per-node failure walks.
module sfnf_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   input  sfnf_pkg::dp_status_type status,
   output sfnf_pkg::ctrl_cmd_type  cmd
);
   import sfnf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR_S,
      ST_ADD_WR_E,
      ST_CAND,
      ST_POP,
      ST_EXPAND,
      ST_CRIT
   } state_type;

   state_type state_ff, state_in;
   logic      finish_ff, finish_in;

   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      cmd       = '0;
      cmd.rd_src    = RD_WALK;
      cmd.wr_src    = WR_EDGE_START;
      cmd.emit_kind = EMIT_NONE_FOUND;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_cmd == CMD_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = ST_CAND;
               end else if (status.edge_ok) begin
                  state_in = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_EDGE_START;
            state_in   = ST_ADD_WR_S;
         end
         ST_ADD_WR_S: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_EDGE_START;
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_EDGE_END;
            state_in   = ST_ADD_WR_E;
         end
         ST_ADD_WR_E: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_EDGE_END;
            state_in   = ST_IDLE;
         end
         ST_CAND: begin
            if (finish_ff || status.f_done) begin
               // close the run: flush the held node as final, or report none
               finish_in = 1'b1;
               if (status.out_free) begin
                  cmd.emit_en   = 1'b1;
                  cmd.emit_kind = status.hold_valid ? EMIT_HOLD_LAST : EMIT_NONE_FOUND;
                  finish_in     = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (!status.start_ok) begin
               state_in = ST_CRIT;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_POP;
            end
         end
         ST_POP: begin
            if (status.pending_empty) begin
               if (status.connected) begin
                  cmd.cand_next = 1'b1;
                  state_in      = ST_CAND;
               end else begin
                  state_in = ST_CRIT;
               end
            end else begin
               cmd.walk_pop = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_src   = RD_WALK;
               state_in     = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            cmd.walk_expand = 1'b1;
            state_in        = ST_POP;
         end
         ST_CRIT: begin
            // hold the new node back until the previous one is sent
            if (!status.hold_valid || status.out_free) begin
               cmd.emit_en   = status.hold_valid;
               cmd.emit_kind = EMIT_HOLD_MID;
               cmd.hold_load = 1'b1;
               state_in      = ST_CAND;
               if (status.k_last) begin
                  finish_in = 1'b1;
               end else begin
                  cmd.cand_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         finish_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
      end
   end

endmodule

### tb/sv/tb_single_failure_node_finder_unit.sv
// Testbench for the single failure node finder: edge loads, detection runs, result checks.
`timescale 1ns / 100ps

module tb_single_failure_node_finder_unit;
   import sfnf_pkg::*;

   localparam int          NODES         = MAX_NODES_DEFAULT;
   localparam int          ITEMS_TOTAL   = 470;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TAIL_CYCLES   = 40;
   localparam int          DRAIN_LIMIT   = 50000;
   localparam int          SQUEEZE_AFTER = 150;
   localparam int unsigned SQUEEZE_HOLD  = 300;

   // Critical node predictor and the queue of results it still owes.
   class node_finder_scoreboard;
      logic [NODES-1:0] adj [NODES];
      logic [5:0]       node_count;
      rsp_payload_type  pending [$];
      int unsigned      errors;

      function new();
         for (int i = 0; i < NODES; i++) adj[i] = '0;
         node_count = NODE_COUNT_RESET;
         errors = 0;
      endfunction

      function int unsigned active_nodes();
         return (node_count > NODES) ? NODES : node_count;
      endfunction

      // Size of the component holding the lowest surviving node, failed node removed.
      function int unsigned reached_without(int unsigned failed, int unsigned n);
         logic [NODES-1:0] seen, grown, live;
         int unsigned start;
         start = (failed == 0) ? 1 : 0;
         live = '0;
         for (int i = 0; i < n; i++) live[i] = 1'b1;
         live[failed] = 1'b0;
         seen = '0;
         seen[start] = 1'b1;
         forever begin
            grown = seen;
            for (int i = 0; i < n; i++)
               if (seen[i]) grown = grown | (adj[i] & live);
            if (grown == seen) break;
            seen = grown;
         end
         return $countones(seen);
      endfunction

      // Returns 1 when the transfer is an edge inside the node range or a run.
      function bit note_request(req_payload_type item);
         int unsigned     n, start, k;
         rsp_payload_type staged;
         bit              have_staged;
         n = active_nodes();
         if (item.cmd == CMD_ADD_EDGE) begin
            if (item.edge_start < n && item.edge_end < n) begin
               adj[item.edge_start][item.edge_end] = 1'b1;
               adj[item.edge_end][item.edge_start] = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         k = 0;
         have_staged = 1'b0;
         staged = '0;
         for (int unsigned f = 0; f < n && k < MAX_RESULTS; f++) begin
            start = (f == 0) ? 1 : 0;
            if (start >= n || reached_without(f, n) != n - 1) begin
               if (have_staged) pending.push_back(staged);
               staged.found = 1'b1;
               staged.node_index = 5'(f);
               staged.last = 1'b0;
               have_staged = 1'b1;
               k++;
            end
         end
         if (!have_staged) begin
            staged.found = 1'b0;
            staged.node_index = '0;
         end
         staged.last = 1'b1;
         pending.push_back(staged);
         return 1'b1;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, got found=%b node_index=%0d last=%b",
                     $time, got.found, got.node_index, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("found", 8'(want.found), 8'(got.found));
         compare_field("node_index", 8'(want.node_index), 8'(got.node_index));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid;
   logic                    req_ready;
   req_payload_type         req_payload;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_payload_type         rsp_payload;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   node_finder_scoreboard sb;
   bit                    req_offered;
   int unsigned           req_calm_left;
   int unsigned           applied_items;
   bit                    squeeze_now;

   single_failure_node_finder_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_payload_type edge_item(logic [5:0] a, logic [5:0] b);
      req_payload_type item;
      item.cmd = CMD_ADD_EDGE;
      item.edge_start = a;
      item.edge_end = b;
      return item;
   endfunction

   function automatic req_payload_type run_item();
      req_payload_type item;
      item.cmd = CMD_RUN;
      item.edge_start = 6'($urandom);
      item.edge_end = 6'($urandom);
      return item;
   endfunction

   function automatic req_payload_type random_item(int unsigned n);
      int unsigned r;
      logic [5:0]  node;
      r = $urandom_range(0, 19);
      if (r < 12) return run_item();
      if (r < 15 && n >= 2)
         return edge_item(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
      if (r < 17 && n >= 1) begin
         node = 6'($urandom_range(0, n - 1));
         return edge_item(node, node);
      end
      return edge_item(6'($urandom), 6'($urandom));
   endfunction

   // Offer one item and hold it until the transfer; valid stays high for a back-to-back item.
   task automatic push_item(input req_payload_type item);
      int unsigned gap;
      if (req_calm_left != 0) begin
         req_calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 29) == 0) begin
         req_calm_left = $urandom_range(15, 50);
         gap = 0;
      end else begin
         gap = idle_length();
      end
      if (gap != 0 && req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      req_offered = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (sb.note_request(item)) applied_items++;
   endtask

   // Drop valid, wait out every expected result and the last edge update.
   task automatic settle_idle();
      if (req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [5:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_NODE_COUNT, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.node_count = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned calm_left;
      rsp_ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (squeeze_now) begin
               squeeze_now = 1'b0;
               stall_left = SQUEEZE_HOLD;
            end else if (calm_left != 0) begin
               calm_left--;
            end else if ($urandom_range(0, 39) == 0) begin
               calm_left = $urandom_range(20, 80);
            end else begin
               stall_left = idle_length();
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #100_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned grow_n, attached, cnt, n_eff, steps, waited;
      bit          squeeze_done;
      logic [5:0]  a, b;
      sb = new();
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_offered = 1'b0;
      req_calm_left = 0;
      applied_items = 0;
      squeeze_now = 1'b0;
      squeeze_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One node after reset: node 0 is critical; self loop kept, wide edges dropped.
      push_item(run_item());
      push_item(edge_item(6'd0, 6'd0));
      push_item(edge_item(6'd0, 6'd1));
      push_item(edge_item(6'd63, 6'd63));
      push_item(run_item());
      // No nodes in use.
      settle_idle();
      write_node_count(6'd0);
      push_item(edge_item(6'd0, 6'd0));
      push_item(run_item());
      // Disconnected, then a path with its middle node critical.
      settle_idle();
      write_node_count(6'd3);
      push_item(run_item());
      push_item(edge_item(6'd0, 6'd1));
      push_item(edge_item(6'd2, 6'd1));
      push_item(run_item());
      settle_idle();
      write_node_count(6'd2);
      push_item(run_item());
      // Count beyond the matrix saturates; almost every node isolated gives a full result list.
      settle_idle();
      write_node_count(6'd63);
      push_item(edge_item(6'd31, 6'd32));
      push_item(edge_item(6'd2, 6'd40));
      push_item(edge_item(6'd31, 6'd0));
      push_item(run_item());
      settle_idle();
      write_node_count(6'd32);
      push_item(edge_item(6'd5, 6'd5));
      push_item(run_item());

      // Grow the node set as a tree with a few chords so critical nodes keep showing up.
      grow_n = 3;
      attached = 3;
      while (applied_items < ITEMS_TOTAL) begin
         settle_idle();
         case ($urandom_range(0, 15))
            0:       cnt = $urandom_range(33, 63);
            1:       cnt = $urandom_range(0, 1);
            2, 3, 4: cnt = $urandom_range(2, grow_n);
            default: begin
               grow_n = grow_n + $urandom_range(1, 2);
               if (grow_n > NODES) grow_n = NODES;
               cnt = grow_n;
            end
         endcase
         write_node_count(6'(cnt));
         n_eff = (cnt > NODES) ? NODES : cnt;
         while (attached < n_eff) begin
            a = 6'(attached);
            b = 6'($urandom_range(0, attached - 1));
            if ($urandom_range(0, 1) == 1) push_item(edge_item(a, b));
            else push_item(edge_item(b, a));
            attached++;
         end
         steps = $urandom_range(3, 10);
         // Hold off the result side while items keep coming.
         if (!squeeze_done && applied_items >= SQUEEZE_AFTER) begin
            squeeze_done = 1'b1;
            squeeze_now = 1'b1;
            steps = 12;
         end
         repeat (steps) push_item(random_item(n_eff));
      end

      if (req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      waited = 0;
      while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### single_failure_node_finder_unit.f
sv/sfnf_pkg.sv
sv/sfnf_datapath.sv
sv/sfnf_controller.sv
sv/single_failure_node_finder_unit.sv
tb/sv/tb_single_failure_node_finder_unit.sv
